// ===== src/rmfls_pkg.sv =====
// ----------------------------------------------------------------------------
// rmfls_pkg
// shared types and constants of the rgb matrix frame loader and scanner
// ----------------------------------------------------------------------------
package rmfls_pkg;

    localparam int PACKET_BYTES = 24;
    localparam int COLOR_SPAN   = 8;

    // byte position codes beyond the data bytes
    localparam logic [4:0] POS_COMMAND = 5'd30;
    localparam logic [4:0] POS_IDLE    = 5'd31;
    localparam logic [4:0] POS_END     = 5'(PACKET_BYTES);

    typedef enum logic [1:0] {
        COLOR_RED   = 2'd0,
        COLOR_GREEN = 2'd1,
        COLOR_BLUE  = 2'd2
    } t_color;

    localparam logic [7:0] DEF_RED   [COLOR_SPAN] =
        '{8'hFF, 8'h81, 8'h81, 8'h99, 8'h99, 8'h81, 8'h81, 8'hFF};
    localparam logic [7:0] DEF_GREEN [COLOR_SPAN] =
        '{8'h00, 8'h7E, 8'h42, 8'h5A, 8'h5A, 8'h42, 8'h7E, 8'h00};
    localparam logic [7:0] DEF_BLUE  [COLOR_SPAN] =
        '{8'h00, 8'h00, 8'h3C, 8'h3C, 8'h3C, 8'h3C, 8'h00, 8'h00};

    // power-up pattern of slot zero
    function automatic logic [7:0] default_row(input t_color color, input logic [2:0] col);
        logic [7:0] row;
        case (color)
            COLOR_RED:   row = DEF_RED[col];
            COLOR_GREEN: row = DEF_GREEN[col];
            COLOR_BLUE:  row = DEF_BLUE[col];
            default:     row = 8'h00;
        endcase
        return row;
    endfunction

endpackage

// ===== src/rmfls_ram.sv =====
// ----------------------------------------------------------------------------
// rmfls_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rmfls_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/rgb_matrix_frame_loader_scanner.sv =====
// ----------------------------------------------------------------------------
// rgb_matrix_frame_loader_scanner
// 8x8 rgb led matrix column scanner fed from a ring of frame slots
// ----------------------------------------------------------------------------
// Takes one request per cycle while s_tready is high. A received byte
// (tuser[0]=0) updates the slot pointers and writes at most one row byte in
// the same cycle; it gives no result. A scan tick (tuser[0]=1) reads the
// three color rams at the shown column. Its result passes the ram read
// stage, then the output register, before it is offered on the master side,
// which adds latency but no gap between requests. Apart from the clearing
// pass, s_tready drops only while a tick result waits in both the read stage
// and a stalled output register. After reset the frame rams are cleared in a
// pass over all FRAME_SLOTS*8 addresses (slot zero gets the power-up pattern)
// during which s_tready is low.
module rgb_matrix_frame_loader_scanner #(
    parameter int FRAME_SLOTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // data_byte
    input  logic [1:0]  s_tuser,    // action, start_seen
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // column, red, green, blue, token, advanced, pad
);

    localparam int SW    = $clog2(FRAME_SLOTS);
    localparam int DEPTH = FRAME_SLOTS * rmfls_pkg::COLOR_SPAN;
    localparam int AW    = SW + 3;
    localparam logic [SW-1:0] LAST_SLOT = SW'(FRAME_SLOTS - 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);

    function automatic logic [SW-1:0] slot_next(input logic [SW-1:0] s);
        return (s == LAST_SLOT) ? '0 : SW'(s + 1'b1);
    endfunction

    logic [SW-1:0] r_ws, r_rs, r_ds;
    logic [5:0]    r_scan;
    logic [4:0]    r_pos;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_s1_valid, r_s1_tok, r_s1_adv;
    logic [2:0]    r_s1_col;
    logic          r_out_valid;
    logic [31:0]   r_out_data;

    logic [SW-1:0] n_ws, n_rs, n_ds;
    logic [5:0]    n_scan;
    logic [4:0]    n_pos;

    logic acc, byte_acc, tick_acc, start, ring_full, out_free, tick_adv, byte_wr;
    logic [4:0]    pos_eff;
    logic [SW-1:0] ws_eff;
    logic [2:0]    col;
    logic [AW-1:0] waddr, raddr;
    logic          we_r, we_g, we_b;
    logic [7:0]    wd_r, wd_g, wd_b;
    logic [7:0]    rd_r, rd_g, rd_b;
    rmfls_pkg::t_color byte_color;

    assign out_free = !r_out_valid || m_tready;
    assign s_tready = !r_clr_busy && !(r_s1_valid && !out_free);
    assign acc      = s_tvalid && s_tready;
    assign byte_acc = acc && !s_tuser[0];
    assign tick_acc = acc && s_tuser[0];
    assign start    = s_tuser[1];

    // byte side: claim on start (or go idle if the ring is full), then skip the command byte, then fill
    assign ring_full = (slot_next(r_ws) == r_rs);
    assign pos_eff   = !start    ? r_pos :
                       ring_full ? rmfls_pkg::POS_IDLE : rmfls_pkg::POS_COMMAND;
    assign ws_eff    = (start && !ring_full) ? slot_next(r_ws) : r_ws;
    assign byte_wr   = byte_acc && (pos_eff < rmfls_pkg::POS_END);
    assign byte_color = rmfls_pkg::t_color'(pos_eff[4:3]);

    always_comb begin
        n_ws  = r_ws;
        n_pos = r_pos;
        if (byte_acc) begin
            n_ws = ws_eff;
            if (pos_eff == rmfls_pkg::POS_COMMAND) begin
                n_pos = '0;
            end else if (pos_eff < rmfls_pkg::POS_END) begin
                n_pos = pos_eff + 5'd1;
            end else begin
                n_pos = pos_eff;
            end
        end
    end

    // tick side
    assign col      = r_scan[2:0];
    assign tick_adv = (n_scan == '0) && (r_rs != r_ws);

    always_comb begin
        n_scan = r_scan + 6'd1;
        n_rs   = r_rs;
        n_ds   = r_ds;
        if (tick_acc && tick_adv) begin
            n_ds = r_rs;
            n_rs = slot_next(r_rs);
        end
    end

    // ram write port: clearing pass or one received byte
    always_comb begin
        if (r_clr_busy) begin
            waddr = r_clr_addr;
            we_r  = 1'b1;
            we_g  = 1'b1;
            we_b  = 1'b1;
            if (r_clr_addr[AW-1:3] == '0) begin
                wd_r = rmfls_pkg::default_row(rmfls_pkg::COLOR_RED, r_clr_addr[2:0]);
                wd_g = rmfls_pkg::default_row(rmfls_pkg::COLOR_GREEN, r_clr_addr[2:0]);
                wd_b = rmfls_pkg::default_row(rmfls_pkg::COLOR_BLUE, r_clr_addr[2:0]);
            end else begin
                wd_r = '0;
                wd_g = '0;
                wd_b = '0;
            end
        end else begin
            waddr = {ws_eff, pos_eff[2:0]};
            wd_r  = s_tdata;
            wd_g  = s_tdata;
            wd_b  = s_tdata;
            we_r  = byte_wr && (byte_color == rmfls_pkg::COLOR_RED);
            we_g  = byte_wr && (byte_color == rmfls_pkg::COLOR_GREEN);
            we_b  = byte_wr && (byte_color == rmfls_pkg::COLOR_BLUE);
        end
    end

    assign raddr = {r_ds, col};

    rmfls_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_red (
        .i_clk(i_clk), .i_we(we_r), .i_waddr(waddr), .i_wdata(wd_r),
        .i_re(tick_acc), .i_raddr(raddr), .o_rdata(rd_r)
    );

    rmfls_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_green (
        .i_clk(i_clk), .i_we(we_g), .i_waddr(waddr), .i_wdata(wd_g),
        .i_re(tick_acc), .i_raddr(raddr), .o_rdata(rd_g)
    );

    rmfls_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram_blue (
        .i_clk(i_clk), .i_we(we_b), .i_waddr(waddr), .i_wdata(wd_b),
        .i_re(tick_acc), .i_raddr(raddr), .o_rdata(rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws        <= '0;
            r_rs        <= '0;
            r_ds        <= '0;
            r_scan      <= '0;
            r_pos       <= rmfls_pkg::POS_IDLE;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_ws  <= n_ws;
            r_rs  <= n_rs;
            r_ds  <= n_ds;
            r_pos <= n_pos;
            if (tick_acc) begin
                r_scan <= n_scan;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_ADDR) begin
                    r_clr_busy <= 1'b0;
                end
            end
            if (tick_acc) begin
                r_s1_valid <= 1'b1;
            end else if (out_free) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tick_acc) begin
            r_s1_col <= col;
            r_s1_tok <= (n_scan[2:0] == 3'd0);
            r_s1_adv <= tick_adv;
        end
        if (out_free && r_s1_valid) begin
            r_out_data <= {3'b000, r_s1_adv, r_s1_tok, rd_b, rd_g, rd_r, r_s1_col};
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = r_out_data;

endmodule

// ===== src/rmfls_checker.sv =====
// ----------------------------------------------------------------------------
// rmfls_checker
// port-level checks of the rgb matrix frame loader and scanner
// ----------------------------------------------------------------------------
module rmfls_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // token exactly on the last column of a sweep
    a_token_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[27] == (m_tdata[2:0] == 3'd7)))
        else $error("column token out of step with column");

    // frame change only on the last column of a sweep, with the token
    a_adv_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[28] |-> m_tdata[27] && (m_tdata[2:0] == 3'd7))
        else $error("frame advanced off a scan boundary");

    // reset empties the output and starts the clearing pass
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid && !s_tready)
        else $error("not quiet after reset");

endmodule

bind rgb_matrix_frame_loader_scanner rmfls_checker u_rmfls_checker (.*);

// ===== dv/rmfls_scoreboard.sv =====
// ----------------------------------------------------------------------------
// rmfls_scoreboard
// Watches the request and result streams of the rgb matrix frame loader and
// scanner. Keeps its own copy of the frame slots, the ring pointers and the
// scan counter. Each accepted scan tick queues the expected column output.
// Each accepted result is checked field by field against the oldest entry.
// ----------------------------------------------------------------------------
module rmfls_scoreboard #(
    parameter int FRAME_SLOTS = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [7:0]  i_s_tdata,    // data_byte
    input  logic [1:0]  i_s_tuser,    // action, start_seen
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // column, red, green, blue, token, advanced, pad
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_BYTES = FRAME_SLOTS * rmfls_pkg::PACKET_BYTES;

    typedef struct packed {
        logic       advanced;
        logic       token;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [2:0] column;
    } t_scan_out;

    logic [7:0] frame_bytes [STORE_BYTES];
    int         fill_slot;
    int         next_show_slot;
    int         shown_slot;
    logic [5:0] tick_count;
    logic [4:0] byte_pos;
    t_scan_out  expected_scans [$];
    int         fail_count;

    assign o_fail_count = fail_count;
    assign o_pending    = expected_scans.size();

    function automatic int ring_next(input int slot);
        return (slot + 1) % FRAME_SLOTS;
    endfunction

    task automatic clear_frames();
        for (int i = 0; i < STORE_BYTES; i++) begin
            frame_bytes[i] = 8'h00;
        end
        for (int c = 0; c < rmfls_pkg::COLOR_SPAN; c++) begin
            frame_bytes[c]                             = rmfls_pkg::DEF_RED[c];
            frame_bytes[c + rmfls_pkg::COLOR_SPAN]     = rmfls_pkg::DEF_GREEN[c];
            frame_bytes[c + 2 * rmfls_pkg::COLOR_SPAN] = rmfls_pkg::DEF_BLUE[c];
        end
        fill_slot      = 0;
        next_show_slot = 0;
        shown_slot     = 0;
        tick_count     = '0;
        byte_pos       = rmfls_pkg::POS_IDLE;
    endtask

    task automatic load_byte(input logic start, input logic [7:0] value);
        if (start) begin
            if (ring_next(fill_slot) != next_show_slot) begin
                fill_slot = ring_next(fill_slot);
                byte_pos  = rmfls_pkg::POS_COMMAND;
            end else begin
                byte_pos = rmfls_pkg::POS_IDLE;
            end
        end
        if (byte_pos == rmfls_pkg::POS_COMMAND) begin
            byte_pos = '0;
        end else if (int'(byte_pos) < rmfls_pkg::PACKET_BYTES) begin
            frame_bytes[fill_slot * rmfls_pkg::PACKET_BYTES + int'(byte_pos)] = value;
            byte_pos = byte_pos + 5'd1;
        end
    endtask

    function automatic t_scan_out scan_column();
        t_scan_out r;
        int        base;
        r.column   = tick_count[2:0];
        base       = shown_slot * rmfls_pkg::PACKET_BYTES + int'(r.column);
        r.red      = frame_bytes[base];
        r.green    = frame_bytes[base + rmfls_pkg::COLOR_SPAN];
        r.blue     = frame_bytes[base + 2 * rmfls_pkg::COLOR_SPAN];
        r.advanced = 1'b0;
        tick_count = tick_count + 6'd1;
        r.token    = (tick_count[2:0] == 3'd0);
        if (tick_count == 6'd0 && next_show_slot != fill_slot) begin
            shown_slot     = next_show_slot;
            next_show_slot = ring_next(next_show_slot);
            r.advanced     = 1'b1;
        end
        return r;
    endfunction

    task automatic note_error(input string what, input int exp_v, input int act_v);
        if (fail_count < 10) begin
            $display("%0t ns: %s expected 0x%0h got 0x%0h", $time, what, exp_v, act_v);
        end
        fail_count++;
    endtask

    initial begin
        fail_count = 0;
        clear_frames();
    end

    always @(posedge i_clk) begin
        t_scan_out exp_r;
        t_scan_out act_r;
        if (!i_rst_n) begin
            clear_frames();
            expected_scans.delete();
        end else begin
            // results first: a tick taken at this edge cannot leave at the same edge
            if (i_m_tvalid && i_m_tready) begin
                act_r = t_scan_out'(i_m_tdata[28:0]);
                if (expected_scans.size() == 0) begin
                    note_error("unexpected result, data", 0, int'(i_m_tdata));
                end else begin
                    exp_r = expected_scans.pop_front();
                    if (act_r.column != exp_r.column)
                        note_error("column", exp_r.column, act_r.column);
                    if (act_r.red != exp_r.red)
                        note_error("red row", exp_r.red, act_r.red);
                    if (act_r.green != exp_r.green)
                        note_error("green row", exp_r.green, act_r.green);
                    if (act_r.blue != exp_r.blue)
                        note_error("blue row", exp_r.blue, act_r.blue);
                    if (act_r.token != exp_r.token)
                        note_error("column token", exp_r.token, act_r.token);
                    if (act_r.advanced != exp_r.advanced)
                        note_error("frame advanced", exp_r.advanced, act_r.advanced);
                    if (i_m_tdata[31:29] != 3'b000)
                        note_error("pad bits", 0, i_m_tdata[31:29]);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser[0]) begin
                    expected_scans.push_back(scan_column());
                end else begin
                    load_byte(i_s_tuser[1], i_s_tdata);
                end
            end
        end
    end

endmodule

// ===== dv/tb_rgb_matrix_frame_loader_scanner.sv =====
// ----------------------------------------------------------------------------
// tb_rgb_matrix_frame_loader_scanner
// Drives bus bytes and scan ticks into the frame loader and scanner. A short
// directed run covers the power-up pattern, dropped and refused bytes and the
// extreme byte values; random frame loads, tick runs up to the frame advance
// and noise follow, with random gaps and output stalls until the final stretch.
// ----------------------------------------------------------------------------
module tb_rgb_matrix_frame_loader_scanner;
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic {
        ACT_BYTE = 1'b0,
        ACT_TICK = 1'b1
    } t_action;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 420;
    localparam int CALM_ITEMS  = 340;
    localparam int PACKET_BYTES_TB = rmfls_pkg::PACKET_BYTES;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;    // data_byte
    logic [1:0]  s_tuser;    // action, start_seen
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;    // column, red, green, blue, token, advanced, pad

    int fail_count;
    int pending;
    int cycles = 0;
    int items_sent = 0;
    int ticks_sent = 0;
    bit calm = 1'b0;
    int stall_left = 0;

    rgb_matrix_frame_loader_scanner #(.FRAME_SLOTS(2)) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rmfls_scoreboard #(.FRAME_SLOTS(2)) u_scoreboard (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // output stalls in random bursts
    always @(negedge i_clk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // called at a falling edge, returns at a falling edge
    task automatic send_request(input t_action act, input logic start, input logic [7:0] value);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= {start, act};
        s_tdata  <= value;
        do @(posedge i_clk); while (!s_tready);
        items_sent++;
        if (act == ACT_TICK) ticks_sent++;
        if (items_sent >= CALM_ITEMS) calm = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_ticks(input int count);
        for (int i = 0; i < count; i++) begin
            send_request(ACT_TICK, 1'($urandom), 8'($urandom));
        end
    endtask

    task automatic send_frame();
        int data_count;
        int roll;
        roll       = $urandom_range(0, 9);
        data_count = PACKET_BYTES_TB;
        if (roll < 2) data_count = $urandom_range(0, PACKET_BYTES_TB - 1);
        else if (roll < 4) data_count = PACKET_BYTES_TB + $urandom_range(1, 3);
        send_request(ACT_BYTE, 1'b1, 8'($urandom));
        for (int i = 0; i < data_count; i++) begin
            if ($urandom_range(0, 7) == 0) send_ticks($urandom_range(1, 6));
            send_request(ACT_BYTE, 1'b0, 8'($urandom));
        end
    endtask

    initial begin
        int kind;
        i_rst_n  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        s_tuser  = 2'b00;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // power-up pattern, start flag on a tick is ignored
        send_request(ACT_TICK, 1'b0, 8'h00);
        send_request(ACT_TICK, 1'b1, 8'hFF);
        // idle loader drops a byte
        send_request(ACT_BYTE, 1'b0, 8'hFF);
        // claim slot one, command byte skipped, extreme data values
        send_request(ACT_BYTE, 1'b1, 8'h00);
        send_request(ACT_BYTE, 1'b0, 8'hFF);
        send_request(ACT_BYTE, 1'b0, 8'h00);
        send_request(ACT_BYTE, 1'b0, 8'hA5);
        send_request(ACT_BYTE, 1'b0, 8'h5A);
        send_request(ACT_BYTE, 1'b0, 8'h80);
        send_request(ACT_BYTE, 1'b0, 8'h01);
        // ring full: start refused and following byte dropped
        send_request(ACT_BYTE, 1'b1, 8'h33);
        send_request(ACT_BYTE, 1'b0, 8'h44);
        send_ticks(10);

        while (items_sent < ITEM_TARGET) begin
            kind = $urandom_range(0, 9);
            if (kind < 5) begin
                send_frame();
            end else if (kind < 8) begin
                if ($urandom_range(0, 1) == 0) send_ticks(64 - (ticks_sent % 64));
                else send_ticks($urandom_range(1, 16));
            end else begin
                repeat ($urandom_range(1, 4)) begin
                    send_request(t_action'($urandom_range(0, 1)), 1'($urandom), 8'($urandom));
                end
            end
        end
        s_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rmfls_pkg.sv
src/rmfls_ram.sv
src/rgb_matrix_frame_loader_scanner.sv
src/rmfls_checker.sv
dv/rmfls_scoreboard.sv
dv/tb_rgb_matrix_frame_loader_scanner.sv
